@@ hdl/arp_pkg.sv @@
package arp_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  // Input commands.
  localparam logic [1:0] CMD_QUERY = 2'd0;
  localparam logic [1:0] CMD_PKT   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_HIT     = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;
  localparam logic [1:0] KIND_LEARNED = 2'd3;

  // ARP operations.
  localparam logic [15:0] OPC_REQUEST = 16'd1;
  localparam logic [15:0] OPC_REPLY   = 16'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_IP0     = 3'd0;
  localparam logic [2:0] REG_MAC0    = 3'd1;
  localparam logic [2:0] REG_IP1     = 3'd2;
  localparam logic [2:0] REG_MAC1    = 3'd3;
  localparam logic [2:0] REG_EXPIRE  = 3'd4;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  // One cache entry as stored in memory.
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] life;
  } entry_t;

endpackage

@@ hdl/arp_cache_responder.sv @@
// ARP responder with an aging IPv4-to-MAC cache.
// Input words arrive on in_valid/in_ready; cmd selects a query, a received
// ARP packet or one aging tick. Results leave on out_valid/out_ready, at
// most two per input word, with out_last set on the final one.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// used only while the block is idle.
// The cache lives in one synchronous memory, one entry read per cycle.
// Every command scans all CACHE_ENTRIES entries through that single read
// port; a word without results returns to idle once the scan is done. A
// learned response first writes its entry, and each result word is then
// loaded into the output register as soon as that register is free.
// Reset clears the valid bits (flip-flops, one per entry), so no clearing
// pass is needed. Results are held in an output register; a stall holds
// them there, and no new input is accepted until all results of the
// current word have been taken.
module arp_cache_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic        in_rx_port,
  input  logic        in_frame_short,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [7:0]  in_hw_len,
  input  logic [7:0]  in_proto_len,
  input  logic [15:0] in_opcode,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_sender_ip,
  input  logic [31:0] in_target_ip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic        out_port,
  output logic [47:0] out_dest_mac,
  output logic [1:0]  out_opcode,
  output logic [47:0] out_sender_mac,
  output logic [31:0] out_sender_ip,
  output logic [47:0] out_target_mac,
  output logic [31:0] out_target_ip,
  output logic        out_last
);
  import arp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WRITE, S_EMIT0, S_EMIT1, S_WAIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [31:0] ip0_r, ip1_r, expire_r;
  logic [47:0] mac0_r, mac1_r;

  // Latched input word.
  logic [1:0]  cmd_r;
  logic        port_r;
  logic        pkt_ok_r;
  logic [15:0] op_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r, tip_r;

  // Cache memory and valid bits.
  entry_t mem [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_r;
  entry_t rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // Scan bookkeeping.
  logic [CNT_W-1:0] issue_r;    // next address to read
  logic             rd_vld_r;   // rd_q holds a fresh read
  logic [IDX_W-1:0] rd_idx_r;   // address of rd_q
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [47:0]      hit_mac_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [31:0]      min_life_r;
  logic [IDX_W-1:0] min_idx_r;
  logic             min_seen_r;
  logic [IDX_W-1:0] slot_r;

  // Output register.
  logic        ov_r;
  logic [1:0]  kind_r, oop_r;
  logic        oport_r, last_r;
  logic [47:0] dmac_r, osmac_r, otmac_r;
  logic [31:0] osip_r, otip_r;

  logic in_fire, out_free, pkt_ok;
  logic cur_valid;
  logic [1:0] nres;
  logic       m0, m1;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !ov_r || out_ready;
  assign pkt_ok    = !in_frame_short && in_hw_type == 16'h0001 &&
                     in_proto_type == 16'h0800 && in_hw_len == 8'd6 &&
                     in_proto_len == 8'd4;
  assign rd_addr   = issue_r[IDX_W-1:0];
  assign cur_valid = valid_r[rd_idx_r];
  assign m0 = (tip_r == ip0_r);
  assign m1 = (tip_r == ip1_r);

  // Memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Write-back selection: aging during a tick scan, insert after a scan.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = rd_idx_r;
    wr_data = rd_q;
    if (state_r == S_SCAN && rd_vld_r && cmd_r == CMD_TICK && cur_valid) begin
      mem_we       = 1'b1;
      wr_data.life = rd_q.life - 32'd1;
    end else if (state_r == S_WRITE) begin
      mem_we  = 1'b1;
      wr_addr = slot_r;
      wr_data = '{ip: sip_r, mac: smac_r, life: expire_r};
    end
  end

  // Number of results of the current word, known after the scan.
  always_comb begin
    nres = 2'd0;
    unique case (cmd_r)
      CMD_QUERY: nres = hit_r ? 2'd1 : 2'd2;
      CMD_PKT: begin
        if (pkt_ok_r && op_r == OPC_REQUEST) begin
          nres = {1'b0, m0} + {1'b0, m1};
        end else if (pkt_ok_r && op_r == OPC_REPLY) begin
          nres = 2'd1;
        end
      end
      default: nres = 2'd0;
    endcase
  end

  // Control, scan and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      ov_r     <= 1'b0;
      rd_vld_r <= 1'b0;
      issue_r  <= '0;
      ip0_r    <= '0;
      ip1_r    <= '0;
      mac0_r   <= '0;
      mac1_r   <= '0;
      expire_r <= 32'd1000;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IP0:    ip0_r    <= cfg_data[31:0];
          REG_MAC0:   mac0_r   <= cfg_data;
          REG_IP1:    ip1_r    <= cfg_data[31:0];
          REG_MAC1:   mac1_r   <= cfg_data;
          REG_EXPIRE: expire_r <= cfg_data[31:0];
          default: ;
        endcase
      end
      // The emit states reload the output register themselves.
      if (ov_r && out_ready && state_r != S_EMIT0 && state_r != S_EMIT1) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r      <= in_cmd;
            port_r     <= in_rx_port;
            pkt_ok_r   <= pkt_ok;
            op_r       <= in_opcode;
            smac_r     <= in_sender_mac;
            sip_r      <= in_sender_ip;
            tip_r      <= in_target_ip;
            hit_r      <= 1'b0;
            free_r     <= 1'b0;
            min_seen_r <= 1'b0;
            issue_r    <= '0;
            rd_vld_r   <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue one read a cycle, evaluate the previous one.
          if (issue_r < CNT_W'(CACHE_ENTRIES)) begin
            issue_r  <= issue_r + 1'b1;
            rd_idx_r <= rd_addr;
            rd_vld_r <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r) begin
            if (cmd_r == CMD_TICK) begin
              if (cur_valid && rd_q.life <= 32'd1) begin
                valid_r[rd_idx_r] <= 1'b0;
              end
            end else begin
              // Lookup key: target for a query, sender for a received packet.
              if (cur_valid && !hit_r &&
                  rd_q.ip == ((cmd_r == CMD_QUERY) ? tip_r : sip_r)) begin
                hit_r     <= 1'b1;
                hit_idx_r <= rd_idx_r;
                hit_mac_r <= rd_q.mac;
              end
              if (!cur_valid && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= rd_idx_r;
              end
              if (cur_valid && (!min_seen_r || rd_q.life < min_life_r)) begin
                min_seen_r <= 1'b1;
                min_life_r <= rd_q.life;
                min_idx_r  <= rd_idx_r;
              end
            end
          end else if (issue_r == CNT_W'(CACHE_ENTRIES)) begin
            // Scan finished.
            slot_r <= hit_r ? hit_idx_r : (free_r ? free_idx_r : min_idx_r);
            if (cmd_r == CMD_PKT && pkt_ok_r && op_r == OPC_REPLY) begin
              state_r <= S_WRITE;
            end else if (nres != 2'd0) begin
              state_r <= S_EMIT0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_WRITE: begin
          valid_r[slot_r] <= 1'b1;
          state_r         <= S_EMIT0;
        end
        S_EMIT0, S_EMIT1: begin
          if (out_free) begin
            ov_r    <= 1'b1;
            last_r  <= (state_r == S_EMIT1) || (nres == 2'd1);
            unique case (cmd_r)
              CMD_QUERY: begin
                oop_r  <= OPC_REQUEST[1:0];
                otip_r <= tip_r;
                if (hit_r) begin
                  kind_r  <= KIND_HIT;
                  oport_r <= 1'b0;
                  dmac_r  <= 48'd0;
                  osmac_r <= 48'd0;
                  osip_r  <= 32'd0;
                  otmac_r <= hit_mac_r;
                end else begin
                  kind_r  <= KIND_REQUEST;
                  oport_r <= (state_r == S_EMIT1);
                  dmac_r  <= MAC_BCAST;
                  osmac_r <= (state_r == S_EMIT1) ? mac1_r : mac0_r;
                  osip_r  <= (state_r == S_EMIT1) ? ip1_r : ip0_r;
                  otmac_r <= 48'd0;
                end
              end
              default: begin
                oop_r   <= OPC_REPLY[1:0];
                oport_r <= port_r;
                if (op_r == OPC_REQUEST) begin
                  kind_r  <= KIND_REPLY;
                  dmac_r  <= smac_r;
                  osmac_r <= port_r ? mac1_r : mac0_r;
                  osip_r  <= (state_r == S_EMIT0 && m0) ? ip0_r : ip1_r;
                  otmac_r <= smac_r;
                  otip_r  <= sip_r;
                end else begin
                  kind_r  <= KIND_LEARNED;
                  dmac_r  <= 48'd0;
                  osmac_r <= smac_r;
                  osip_r  <= sip_r;
                  otmac_r <= 48'd0;
                  otip_r  <= 32'd0;
                end
              end
            endcase
            if (state_r == S_EMIT0 && nres == 2'd2) begin
              state_r <= S_EMIT1;
            end else begin
              state_r <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = ov_r;
  assign out_kind       = kind_r;
  assign out_port       = oport_r;
  assign out_dest_mac   = dmac_r;
  assign out_opcode     = oop_r;
  assign out_sender_mac = osmac_r;
  assign out_sender_ip  = osip_r;
  assign out_target_mac = otmac_r;
  assign out_target_ip  = otip_r;
  assign out_last       = last_r;

endmodule
